// ===== rtl/bitmap_contiguous_allocator_macros.svh =====
// Assertion helpers used by the allocator datapath.
// BCA_ASSERT expects clk_i and rst_ni in the enclosing module; BCA_ASSERT_ALWAYS only clk_i.
`ifndef BITMAP_CONTIGUOUS_ALLOCATOR_MACROS_SVH
`define BITMAP_CONTIGUOUS_ALLOCATOR_MACROS_SVH

// Check on every clock edge outside of reset
`define BCA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check on every clock edge, reset included
`define BCA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== rtl/bca_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bca_pkg;

  // Map geometry: the map is kept as 16-bit segments
  localparam int MAP_BITS = 4096;
  localparam int SEG_BITS = 16;
  localparam int NUM_SEGS = MAP_BITS / SEG_BITS;
  localparam int SEG_AW   = $clog2(NUM_SEGS);
  localparam int BIT_AW   = $clog2(SEG_BITS);

  // Field widths
  localparam int IDX_W = 12;
  localparam int LEN_W = 13;

  localparam logic [LEN_W-1:0] MAP_SIZE    = LEN_W'(MAP_BITS);
  localparam int               CAP_INT     = (MAP_BITS > 8191) ? 8191 : MAP_BITS;
  localparam int               RST_INT     = (MAP_BITS - 1 > 8191) ? 8191 : MAP_BITS - 1;
  localparam logic [LEN_W:0]   TALLY_CAP   = (LEN_W + 1)'(CAP_INT);
  localparam logic [LEN_W-1:0] TALLY_RESET = LEN_W'(RST_INT);

  // Operation codes
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // Configuration port
  localparam int   CFG_AW = 3;
  localparam int   CFG_DW = 32;
  localparam logic REG_TOTAL_SIZE = 1'b0;
  localparam logic [LEN_W-1:0] TOTAL_SIZE_RESET = LEN_W'(4096);

  typedef logic [SEG_BITS-1:0] seg_t;

  // Datapath actions, one per microcode step
  typedef enum logic [3:0] {
    ACT_NOP,
    ACT_LATCH,
    ACT_SCAN_INIT,
    ACT_SCAN,
    ACT_FREE_INIT,
    ACT_RMW_INIT,
    ACT_RMW,
    ACT_COMMIT,
    ACT_RESULT
  } act_e;

  // Branch conditions
  typedef enum logic [3:0] {
    COND_NONE,
    COND_NOT_FIRE,
    COND_IS_FREE,
    COND_BAD_ALLOC,
    COND_SCAN_GO,
    COND_NOT_FOUND,
    COND_BAD_FREE,
    COND_RMW_MORE,
    COND_OUT_BUSY
  } cond_e;

  // Program steps
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_IDLE   = 4'd0;
  localparam logic [STEP_W-1:0] STEP_DISP   = 4'd1;
  localparam logic [STEP_W-1:0] STEP_ACHK   = 4'd2;
  localparam logic [STEP_W-1:0] STEP_SCAN   = 4'd3;
  localparam logic [STEP_W-1:0] STEP_CHKF   = 4'd4;
  localparam logic [STEP_W-1:0] STEP_FCHK   = 4'd5;
  localparam logic [STEP_W-1:0] STEP_RINIT  = 4'd6;
  localparam logic [STEP_W-1:0] STEP_RMW    = 4'd7;
  localparam logic [STEP_W-1:0] STEP_COMMIT = 4'd8;
  localparam logic [STEP_W-1:0] STEP_DONE   = 4'd9;

  typedef struct packed {
    act_e              act;
    cond_e             cond;
    logic [STEP_W-1:0] jmp;
    logic [STEP_W-1:0] nxt;
  } uword_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    logic fire;
    logic is_free;
    logic bad_alloc;
    logic bad_free;
    logic scan_go;
    logic found;
    logic rmw_more;
    logic out_busy;
  } dp_flags_t;

  // Control store: jump to jmp when cond holds, else go to nxt
  function automatic uword_t ucode_rom(input logic [STEP_W-1:0] pc);
    uword_t w;
    case (pc)
      STEP_IDLE:   w = '{act: ACT_LATCH,     cond: COND_NOT_FIRE,  jmp: STEP_IDLE,
                         nxt: STEP_DISP};
      STEP_DISP:   w = '{act: ACT_NOP,       cond: COND_IS_FREE,   jmp: STEP_FCHK,
                         nxt: STEP_ACHK};
      STEP_ACHK:   w = '{act: ACT_SCAN_INIT, cond: COND_BAD_ALLOC, jmp: STEP_DONE,
                         nxt: STEP_SCAN};
      STEP_SCAN:   w = '{act: ACT_SCAN,      cond: COND_SCAN_GO,   jmp: STEP_SCAN,
                         nxt: STEP_CHKF};
      STEP_CHKF:   w = '{act: ACT_NOP,       cond: COND_NOT_FOUND, jmp: STEP_DONE,
                         nxt: STEP_RINIT};
      STEP_FCHK:   w = '{act: ACT_FREE_INIT, cond: COND_BAD_FREE,  jmp: STEP_DONE,
                         nxt: STEP_RINIT};
      STEP_RINIT:  w = '{act: ACT_RMW_INIT,  cond: COND_NONE,      jmp: STEP_IDLE,
                         nxt: STEP_RMW};
      STEP_RMW:    w = '{act: ACT_RMW,       cond: COND_RMW_MORE,  jmp: STEP_RMW,
                         nxt: STEP_COMMIT};
      STEP_COMMIT: w = '{act: ACT_COMMIT,    cond: COND_NONE,      jmp: STEP_IDLE,
                         nxt: STEP_DONE};
      STEP_DONE:   w = '{act: ACT_RESULT,    cond: COND_OUT_BUSY,  jmp: STEP_DONE,
                         nxt: STEP_IDLE};
      default:     w = '{act: ACT_NOP,       cond: COND_NONE,      jmp: STEP_IDLE,
                         nxt: STEP_IDLE};
    endcase
    return w;
  endfunction

  // Segment contents after reset: unit 0 reserved, all others free
  function automatic seg_t seg_reset(input logic [SEG_AW-1:0] seg);
    seg_t w;
    w = '1;
    if (seg == '0) begin
      w[0] = 1'b0;
    end
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/bca_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface bca_req_if;
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic [bca_pkg::IDX_W-1:0]   start_index;
  logic [bca_pkg::LEN_W-1:0]   length;

  modport source (output valid, func, start_index, length, input ready);
  modport sink (input valid, func, start_index, length, output ready);
endinterface

`default_nettype wire

// ===== rtl/bca_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface bca_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [bca_pkg::IDX_W-1:0]   run_start;
  logic                        ok;
  logic [bca_pkg::LEN_W-1:0]   free_units;

  modport source (output valid, run_start, ok, free_units, input ready);
  modport sink (input valid, run_start, ok, free_units, output ready);
endinterface

`default_nettype wire

// ===== rtl/bitmap_contiguous_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none

// First-fit bitmap allocator over 4096 units (unit 0 reserved).
// Requests come in on req_i (func 0 allocates a run of length units, func 1
// frees length units from start_index); one result per request leaves on
// rsp_o with run_start, ok and the free-unit tally after the request.
// total_size is written over the APB port at address 0; pready is always
// high and a write lands at the access cycle.
// The map lives in a 256 x 16-bit RAM with one read port; one segment is
// examined per cycle. An allocate scans segments from segment 0 until the
// run completes or the last segment within size is reached (up to 256),
// then rewrites each segment the run spans and commits; a free checks its
// range, then rewrites and commits the same way; rejected or zero-length
// requests go straight to the result.
// One request is in work at a time; the next is accepted in the cycle after the
// result is loaded, even while that result still waits in the output register.
// Reset marks every unit free but unit 0, sets the tally to 4095 and
// total_size to 4096; segments read as that state until first written, so
// no clearing pass is needed. A stalled receiver holds the result; the
// block finishes its current request and waits for the slot to drain.

module bitmap_contiguous_allocator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bca_pkg::CFG_AW-1:0]    paddr,
  input  logic [bca_pkg::CFG_DW-1:0]    pwdata,
  output logic [bca_pkg::CFG_DW-1:0]    prdata,
  output logic                          pready,
  bca_req_if.sink                       req_i,
  bca_rsp_if.source                     rsp_o
);

  localparam int LEN_W = bca_pkg::LEN_W;

  logic [LEN_W-1:0]      total_size_q;
  logic [LEN_W-1:0]      size;
  logic                  reg_idx;
  logic                  cfg_we;
  bca_pkg::act_e         act;
  bca_pkg::dp_flags_t    flags;

  // Register decode
  assign reg_idx = paddr[bca_pkg::CFG_AW-1];
  assign cfg_we  = psel && penable && pwrite && (reg_idx == bca_pkg::REG_TOTAL_SIZE);
  assign pready  = 1'b1;
  assign prdata  = (reg_idx == bca_pkg::REG_TOTAL_SIZE)
                 ? bca_pkg::CFG_DW'(total_size_q) : '0;

  // Hold total_size
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_size_q <= bca_pkg::TOTAL_SIZE_RESET;
    end else if (cfg_we) begin
      total_size_q <= pwdata[LEN_W-1:0];
    end
  end

  // Clamp to the map size
  assign size = (total_size_q > bca_pkg::MAP_SIZE) ? bca_pkg::MAP_SIZE : total_size_q;

  bca_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .act_o   (act)
  );

  bca_dp u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .act_i   (act),
    .size_i  (size),
    .flags_o (flags),
    .req_i   (req_i),
    .rsp_o   (rsp_o)
  );

endmodule

`default_nettype wire

// ===== rtl/bca_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bca_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write one word, read one word with registered output
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/bca_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bca_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bca_pkg::dp_flags_t  flags_i,
  output bca_pkg::act_e       act_o
);

  logic [bca_pkg::STEP_W-1:0] pc_q, pc_d;
  bca_pkg::uword_t            uw;
  logic                       take;

  // Fetch the control word of the current step
  assign uw    = bca_pkg::ucode_rom(pc_q);
  assign act_o = uw.act;

  // Evaluate the branch condition
  always_comb begin
    case (uw.cond)
      bca_pkg::COND_NONE:      take = 1'b0;
      bca_pkg::COND_NOT_FIRE:  take = !flags_i.fire;
      bca_pkg::COND_IS_FREE:   take = flags_i.is_free;
      bca_pkg::COND_BAD_ALLOC: take = flags_i.bad_alloc;
      bca_pkg::COND_SCAN_GO:   take = flags_i.scan_go;
      bca_pkg::COND_NOT_FOUND: take = !flags_i.found;
      bca_pkg::COND_BAD_FREE:  take = flags_i.bad_free;
      bca_pkg::COND_RMW_MORE:  take = flags_i.rmw_more;
      bca_pkg::COND_OUT_BUSY:  take = flags_i.out_busy;
      default:                 take = 1'b0;
    endcase
  end

  assign pc_d = take ? uw.jmp : uw.nxt;

  // Advance the step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= bca_pkg::STEP_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bca_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "bitmap_contiguous_allocator_macros.svh"

module bca_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bca_pkg::act_e               act_i,
  input  logic [bca_pkg::LEN_W-1:0]   size_i,
  output bca_pkg::dp_flags_t          flags_o,
  bca_req_if.sink                     req_i,
  bca_rsp_if.source                   rsp_o
);

  localparam int SEG_BITS = bca_pkg::SEG_BITS;
  localparam int SEG_AW   = bca_pkg::SEG_AW;
  localparam int BIT_AW   = bca_pkg::BIT_AW;
  localparam int IDX_W    = bca_pkg::IDX_W;
  localparam int LEN_W    = bca_pkg::LEN_W;

  // Request and working registers
  logic                 func_q;
  logic [IDX_W-1:0]     start_q;
  logic [LEN_W-1:0]     len_q;
  logic [SEG_AW-1:0]    seg_q;
  logic [LEN_W-1:0]     cnt_q;
  logic                 found_q;
  logic [IDX_W-1:0]     lo_q, hi_q;
  logic                 ok_q;
  logic [IDX_W-1:0]     run_start_q;
  logic [LEN_W-1:0]     tally_q;
  logic [bca_pkg::NUM_SEGS-1:0] valid_q;

  // Result register
  logic                 rsp_valid_q;
  logic [IDX_W-1:0]     rsp_run_start_q;
  logic                 rsp_ok_q;
  logic [LEN_W-1:0]     rsp_free_q;

  logic                 fire;
  logic                 out_busy;
  logic                 rsp_load;

  logic [SEG_AW-1:0]    rd_addr;
  bca_pkg::seg_t        ram_rdata;
  bca_pkg::seg_t        rd_word;
  bca_pkg::seg_t        in_mask;
  bca_pkg::seg_t        w;
  logic [LEN_W-BIT_AW-1:0] seg_ext;
  logic [LEN_W-1:0]     size_m1;
  logic                 last_seg;

  logic [LEN_W-1:0]     rem;
  logic [BIT_AW:0]      zpos   [SEG_BITS];
  logic [BIT_AW:0]      runloc [SEG_BITS];
  logic [SEG_BITS-1:0]  pfx;
  logic [SEG_BITS-1:0]  hitv;
  logic                 hit;
  logic [BIT_AW-1:0]    hit_pos;
  logic [IDX_W-1:0]     end_pos;
  logic [IDX_W-1:0]     run_lo;
  logic [LEN_W-1:0]     cnt_next;

  logic [LEN_W:0]       free_end;
  logic                 bad_free;

  bca_pkg::seg_t        lo_m, hi_m, rmw_mask;
  logic                 ram_we;
  bca_pkg::seg_t        ram_wdata;

  logic [LEN_W-1:0]     alloc_tally;
  logic [LEN_W:0]       free_sum;
  logic [LEN_W-1:0]     free_tally;

  // Handshakes
  assign req_i.ready = (act_i == bca_pkg::ACT_LATCH);
  assign fire        = req_i.valid && req_i.ready;
  assign out_busy    = rsp_valid_q && !rsp_o.ready;
  assign rsp_load    = (act_i == bca_pkg::ACT_RESULT) && !out_busy;

  // Pick the segment to read next
  always_comb begin
    case (act_i)
      bca_pkg::ACT_SCAN_INIT: rd_addr = '0;
      bca_pkg::ACT_SCAN:      rd_addr = seg_q + SEG_AW'(1);
      bca_pkg::ACT_RMW_INIT:  rd_addr = lo_q[IDX_W-1:BIT_AW];
      bca_pkg::ACT_RMW:       rd_addr = seg_q + SEG_AW'(1);
      default:                rd_addr = seg_q;
    endcase
  end

  bca_ram #(
    .WIDTH (SEG_BITS),
    .DEPTH (bca_pkg::NUM_SEGS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (seg_q),
    .wdata_i (ram_wdata),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  // Segments never written read as their reset contents
  assign rd_word = valid_q[seg_q] ? ram_rdata : bca_pkg::seg_reset(seg_q);

  // Drop units at or above the effective size
  assign seg_ext = {1'b0, seg_q};
  always_comb begin
    if (seg_ext < size_i[LEN_W-1:BIT_AW]) begin
      in_mask = '1;
    end else if (seg_ext == size_i[LEN_W-1:BIT_AW]) begin
      in_mask = ~(bca_pkg::seg_t'('1) << size_i[BIT_AW-1:0]);
    end else begin
      in_mask = '0;
    end
  end
  assign w = rd_word & in_mask;

  assign size_m1  = size_i - LEN_W'(1);
  assign last_seg = (seg_q == size_m1[IDX_W-1:BIT_AW]);

  // Run length ending at each bit of the segment, and where it reaches len
  assign rem = len_q - cnt_q;
  always_comb begin
    for (int j = 0; j < SEG_BITS; j++) begin
      zpos[j] = '0;
      for (int k = 0; k < SEG_BITS; k++) begin
        if (k <= j && !w[k]) begin
          zpos[j] = (BIT_AW + 1)'(k + 1);
        end
      end
      pfx[j]    = (zpos[j] == '0);
      runloc[j] = (BIT_AW + 1)'(j + 1) - zpos[j];
      hitv[j]   = w[j] && (pfx[j] ? (LEN_W'(j + 1) >= rem)
                                  : (LEN_W'(runloc[j]) >= len_q));
    end
  end

  // Take the lowest bit at which the run completes
  always_comb begin
    hit_pos = '0;
    for (int j = SEG_BITS - 1; j >= 0; j--) begin
      if (hitv[j]) begin
        hit_pos = BIT_AW'(j);
      end
    end
  end

  assign hit      = |hitv;
  assign end_pos  = {seg_q, hit_pos};
  assign run_lo   = IDX_W'(LEN_W'(end_pos) + LEN_W'(1) - len_q);
  assign cnt_next = pfx[SEG_BITS-1] ? (cnt_q + LEN_W'(SEG_BITS))
                                    : LEN_W'(runloc[SEG_BITS-1]);

  // Free range check: nonempty, clear of unit 0, within size
  assign free_end = (LEN_W + 1)'(start_q) + (LEN_W + 1)'(len_q);
  assign bad_free = (len_q == '0) || (start_q == '0) || (free_end > (LEN_W + 1)'(size_i));

  // Read-modify-write mask for the run segment at hand
  assign lo_m = (seg_q == lo_q[IDX_W-1:BIT_AW])
              ? (bca_pkg::seg_t'('1) << lo_q[BIT_AW-1:0]) : '1;
  assign hi_m = (seg_q == hi_q[IDX_W-1:BIT_AW])
              ? (bca_pkg::seg_t'('1) >> (BIT_AW'(SEG_BITS - 1) - hi_q[BIT_AW-1:0])) : '1;
  assign rmw_mask  = lo_m & hi_m;
  assign ram_we    = (act_i == bca_pkg::ACT_RMW);
  assign ram_wdata = (func_q == bca_pkg::FUNC_FREE) ? (rd_word | rmw_mask)
                                                    : (rd_word & ~rmw_mask);

  // Tally updates, saturating at both ends
  assign alloc_tally = (tally_q > len_q) ? (tally_q - len_q) : '0;
  assign free_sum    = (LEN_W + 1)'(tally_q) + (LEN_W + 1)'(len_q);
  assign free_tally  = (free_sum > bca_pkg::TALLY_CAP) ? bca_pkg::TALLY_CAP[LEN_W-1:0]
                                                       : free_sum[LEN_W-1:0];

  // Status to the sequencer
  always_comb begin
    flags_o.fire      = fire;
    flags_o.is_free   = (func_q == bca_pkg::FUNC_FREE);
    flags_o.bad_alloc = (len_q == '0);
    flags_o.bad_free  = bad_free;
    flags_o.scan_go   = !hit && !last_seg;
    flags_o.found     = found_q;
    flags_o.rmw_more  = (seg_q != hi_q[IDX_W-1:BIT_AW]);
    flags_o.out_busy  = out_busy;
  end

  // Control state: tally, segment valid bits, flags, result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tally_q     <= bca_pkg::TALLY_RESET;
      valid_q     <= '0;
      found_q     <= 1'b0;
      ok_q        <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        found_q <= 1'b0;
        ok_q    <= 1'b0;
      end
      if (act_i == bca_pkg::ACT_SCAN) begin
        found_q <= hit;
      end
      if (ram_we) begin
        valid_q[seg_q] <= 1'b1;
      end
      if (act_i == bca_pkg::ACT_COMMIT) begin
        ok_q    <= 1'b1;
        tally_q <= (func_q == bca_pkg::FUNC_FREE) ? free_tally : alloc_tally;
      end
      if (rsp_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    seg_q <= rd_addr;
    if (fire) begin
      func_q      <= req_i.func;
      start_q     <= req_i.start_index;
      len_q       <= req_i.length;
      run_start_q <= '0;
    end
    case (act_i)
      bca_pkg::ACT_SCAN_INIT: begin
        cnt_q <= '0;
      end
      bca_pkg::ACT_SCAN: begin
        cnt_q <= cnt_next;
        if (hit) begin
          lo_q <= run_lo;
          hi_q <= end_pos;
        end
      end
      bca_pkg::ACT_FREE_INIT: begin
        lo_q <= start_q;
        hi_q <= IDX_W'(LEN_W'(start_q) + len_q - LEN_W'(1));
      end
      bca_pkg::ACT_COMMIT: begin
        run_start_q <= (func_q == bca_pkg::FUNC_FREE) ? '0 : lo_q;
      end
      default: begin
      end
    endcase
    if (rsp_load) begin
      rsp_run_start_q <= run_start_q;
      rsp_ok_q        <= ok_q;
      rsp_free_q      <= tally_q;
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.run_start  = rsp_run_start_q;
  assign rsp_o.ok         = rsp_ok_q;
  assign rsp_o.free_units = rsp_free_q;

  // Writes stay inside the segments of the current run
  `BCA_ASSERT(a_rmw_in_run, ram_we |-> (seg_q >= lo_q[IDX_W-1:BIT_AW]) && (seg_q <= hi_q[IDX_W-1:BIT_AW]), "write outside run segments")
  // Unit 0 is never released
  `BCA_ASSERT_ALWAYS(a_unit0_kept, (ram_we && (seg_q == '0)) |-> !ram_wdata[0], "unit 0 marked free")
  // A found run ends below the effective size
  `BCA_ASSERT(a_run_in_size, ((act_i == bca_pkg::ACT_SCAN) && hit) |-> (LEN_W'(end_pos) < size_i), "run past size")
  // The carried run never reaches the length while scanning
  `BCA_ASSERT(a_cnt_below_len, (act_i == bca_pkg::ACT_SCAN) |-> (cnt_q < len_q), "missed run end")

endmodule

`default_nettype wire
